/* rtl/otb_pkg.sv */
package otb_pkg;

  localparam int NBINS = 256;
  localparam int BIN_W = 8;
  localparam logic [7:0] MASK_SET = 8'd255;
  localparam logic OP_ACC = 1'b0;
  localparam logic OP_CLS = 1'b1;
  localparam logic KIND_THR = 1'b0;
  localparam logic KIND_MASK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_S1_ADDR,
    ST_S1_ACC,
    ST_P2_ADDR,
    ST_P2_LOAD,
    ST_P2_CHECK,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIFF,
    ST_CMP,
    ST_P2_NEXT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_X,
    MS_Y,
    MS_NUM,
    MS_DEN,
    MS_LHS,
    MS_RHS
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     rd_scan;
    logic     acc_wr;
    logic     scan_init;
    logic     sum_acc;
    logic     w_acc;
    logic     bin_inc;
    logic     bin_clr;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     diff;
    logic     cmp_upd;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic split_ok;
    logic bin_last;
    logic mul_done;
  } status_t;

endpackage

/* rtl/otb_ram.sv */
module otb_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/otb_mul.sv */
module otb_mul #(
  parameter int AW = 96,
  parameter int BW = 48,
  localparam int PW = AW + BW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [PW-1:0] p
);

  logic          busy_r;
  logic [PW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic [PW-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= PW'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = busy_r && b_r == '0;
  assign p    = acc_r;

endmodule

/* rtl/otb_ctrl.sv */
module otb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  input  logic             in_last,
  output logic             in_stall,
  input  otb_pkg::status_t sts,
  output otb_pkg::cmd_t    cmd
);

  otb_pkg::state_t   state_r, state_nxt;
  otb_pkg::mul_sel_t step_r, step_nxt;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otb_pkg::ST_IDLE;
      step_r  <= otb_pkg::MS_X;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cmd.accept) begin
        last_r <= in_last;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.mul_sel = step_r;
    cmd.rd_scan = state_r != otb_pkg::ST_IDLE;
    in_stall  = !(state_r == otb_pkg::ST_IDLE && sts.out_free);
    case (state_r)
      otb_pkg::ST_IDLE: begin
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept && in_op == otb_pkg::OP_ACC) begin
          state_nxt = otb_pkg::ST_ACC_WR;
        end
      end
      otb_pkg::ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        if (last_r) begin
          cmd.scan_init = 1'b1;
          state_nxt = otb_pkg::ST_S1_ADDR;
        end else begin
          state_nxt = otb_pkg::ST_IDLE;
        end
      end
      otb_pkg::ST_S1_ADDR: state_nxt = otb_pkg::ST_S1_ACC;
      otb_pkg::ST_S1_ACC: begin
        cmd.sum_acc = 1'b1;
        if (sts.bin_last) begin
          cmd.bin_clr = 1'b1;
          state_nxt = otb_pkg::ST_P2_ADDR;
        end else begin
          cmd.bin_inc = 1'b1;
          state_nxt = otb_pkg::ST_S1_ADDR;
        end
      end
      otb_pkg::ST_P2_ADDR: state_nxt = otb_pkg::ST_P2_LOAD;
      otb_pkg::ST_P2_LOAD: begin
        cmd.w_acc = 1'b1;
        state_nxt = otb_pkg::ST_P2_CHECK;
      end
      otb_pkg::ST_P2_CHECK: begin
        if (sts.split_ok) begin
          step_nxt  = otb_pkg::MS_X;
          state_nxt = otb_pkg::ST_MUL_GO;
        end else begin
          state_nxt = otb_pkg::ST_P2_NEXT;
        end
      end
      otb_pkg::ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt = otb_pkg::ST_MUL_WAIT;
      end
      otb_pkg::ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = otb_pkg::ST_MUL_GO;
          case (step_r)
            otb_pkg::MS_X:   step_nxt = otb_pkg::MS_Y;
            otb_pkg::MS_Y:   state_nxt = otb_pkg::ST_DIFF;
            otb_pkg::MS_NUM: step_nxt = otb_pkg::MS_DEN;
            otb_pkg::MS_DEN: step_nxt = otb_pkg::MS_LHS;
            otb_pkg::MS_LHS: step_nxt = otb_pkg::MS_RHS;
            default:         state_nxt = otb_pkg::ST_CMP;
          endcase
        end
      end
      otb_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        step_nxt  = otb_pkg::MS_NUM;
        state_nxt = otb_pkg::ST_MUL_GO;
      end
      otb_pkg::ST_CMP: begin
        cmd.cmp_upd = 1'b1;
        state_nxt = otb_pkg::ST_P2_NEXT;
      end
      otb_pkg::ST_P2_NEXT: begin
        if (sts.bin_last) begin
          state_nxt = otb_pkg::ST_DONE;
        end else begin
          cmd.bin_inc = 1'b1;
          state_nxt = otb_pkg::ST_P2_ADDR;
        end
      end
      otb_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = otb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = otb_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/otb_dp.sv */
module otb_dp #(
  parameter int COUNT_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  otb_pkg::cmd_t            cmd,
  output otb_pkg::status_t         sts,
  input  logic                     in_op,
  input  logic [otb_pkg::BIN_W-1:0] in_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_kind,
  output logic [7:0]               out_level,
  output logic [7:0]               out_mask,
  output logic                     out_overflow
);

  localparam int C  = COUNT_BITS;
  localparam int SW = C + 8;
  localparam int XW = 2 * C + 8;
  localparam int NW = 4 * C + 16;
  localparam int DW = 2 * C;
  localparam int LW = NW + DW;
  localparam int PW = NW + XW;
  localparam int BW = otb_pkg::BIN_W;

  logic [otb_pkg::NBINS-1:0] vld_r;
  logic          hv_r;
  logic [C-1:0]  rdata, h;
  logic [BW-1:0] rd_addr, pix_r, bin_r, thr_r, level_r;
  logic [C-1:0]  count_r, wb_r, wf;
  logic          full_r, flag_r;
  logic [SW-1:0] s_r, sb_r, bin_h;
  logic [XW-1:0] x_r, y_r, d_r;
  logic [NW-1:0] num_r, best_num_r;
  logic [DW-1:0] den_r, best_den_r;
  logic [LW-1:0] lhs_r, rhs_r;
  logic [NW-1:0] ma;
  logic [XW-1:0] mb;
  logic [PW-1:0] mp;
  logic          mdone;
  logic          out_valid_r, out_kind_r, out_ovf_r;
  logic [7:0]    out_level_r, out_mask_r;

  assign rd_addr = cmd.rd_scan ? bin_r : in_pixel;
  assign h       = hv_r ? rdata : '0;
  assign bin_h   = SW'(bin_r) * SW'(h);
  assign wf      = count_r - wb_r;

  otb_ram #(.WIDTH(C), .DEPTH(otb_pkg::NBINS)) u_hist (
    .clk   (clk),
    .we    (cmd.acc_wr && !full_r),
    .waddr (pix_r),
    .wdata (h + C'(1)),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.mul_sel)
      otb_pkg::MS_X:   begin ma = NW'(sb_r);     mb = XW'(count_r);    end
      otb_pkg::MS_Y:   begin ma = NW'(s_r);      mb = XW'(wb_r);       end
      otb_pkg::MS_NUM: begin ma = NW'(d_r);      mb = d_r;             end
      otb_pkg::MS_DEN: begin ma = NW'(wb_r);     mb = XW'(wf);         end
      otb_pkg::MS_LHS: begin ma = num_r;         mb = XW'(best_den_r); end
      default:         begin ma = best_num_r;    mb = XW'(den_r);      end
    endcase
  end

  otb_mul #(.AW(NW), .BW(XW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      count_r     <= '0;
      flag_r      <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept && in_op == otb_pkg::OP_ACC) begin
        if (count_r == {C{1'b1}}) begin
          flag_r <= 1'b1;
        end else begin
          count_r <= count_r + C'(1);
        end
      end
      if (cmd.accept && in_op == otb_pkg::OP_CLS) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.acc_wr && !full_r) begin
        vld_r[pix_r] <= 1'b1;
      end
      if (cmd.finish) begin
        thr_r       <= level_r;
        out_valid_r <= 1'b1;
        vld_r       <= '0;
        count_r     <= '0;
        flag_r      <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hv_r <= vld_r[rd_addr];
    if (cmd.accept) begin
      pix_r  <= in_pixel;
      full_r <= count_r == {C{1'b1}};
    end
    if (cmd.accept && in_op == otb_pkg::OP_CLS) begin
      out_kind_r  <= otb_pkg::KIND_MASK;
      out_level_r <= '0;
      out_mask_r  <= (in_pixel <= thr_r) ? otb_pkg::MASK_SET : 8'd0;
      out_ovf_r   <= 1'b0;
    end
    if (cmd.finish) begin
      out_kind_r  <= otb_pkg::KIND_THR;
      out_level_r <= level_r;
      out_mask_r  <= '0;
      out_ovf_r   <= flag_r;
    end
    if (cmd.scan_init) begin
      bin_r      <= '0;
      s_r        <= '0;
      sb_r       <= '0;
      wb_r       <= '0;
      level_r    <= '0;
      best_num_r <= '0;
      best_den_r <= DW'(1);
    end
    if (cmd.sum_acc) begin
      s_r <= s_r + bin_h;
    end
    if (cmd.w_acc) begin
      wb_r <= wb_r + h;
      sb_r <= sb_r + bin_h;
    end
    if (cmd.bin_inc) begin
      bin_r <= bin_r + BW'(1);
    end
    if (cmd.bin_clr) begin
      bin_r <= '0;
    end
    if (mdone) begin
      case (cmd.mul_sel)
        otb_pkg::MS_X:   x_r   <= XW'(mp);
        otb_pkg::MS_Y:   y_r   <= XW'(mp);
        otb_pkg::MS_NUM: num_r <= NW'(mp);
        otb_pkg::MS_DEN: den_r <= DW'(mp);
        otb_pkg::MS_LHS: lhs_r <= LW'(mp);
        default:         rhs_r <= LW'(mp);
      endcase
    end
    if (cmd.diff) begin
      d_r <= (x_r >= y_r) ? x_r - y_r : y_r - x_r;
    end
    if (cmd.cmp_upd && lhs_r >= rhs_r) begin
      level_r    <= bin_r;
      best_num_r <= num_r;
      best_den_r <= den_r;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.split_ok = wb_r != '0 && wf != '0;
  assign sts.bin_last = &bin_r;
  assign sts.mul_done = mdone;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_level    = out_level_r;
  assign out_mask     = out_mask_r;
  assign out_overflow = out_ovf_r;

endmodule

/* rtl/otsu_threshold_binarizer.sv */
// Otsu threshold binarizer. Accumulate items (op 0) add a pixel to a 256-bin
// histogram held in a RAM (read, then write back the incremented bin).
// Classify items (op 1) return a mask of 255 or 0 against the stored
// threshold. An accumulate item with last set starts the frame-end scan: a
// pixel-sum pass over all bins, then a per-bin pass that, for every bin with
// a valid split, runs six shift-add multiplications on one shared multiplier.
// The histogram is cleared through per-bin valid bits in the same cycle
// the threshold result is loaded. Pixels past 2^COUNT_BITS-1 per frame are
// dropped and reported on out_overflow with the threshold result.
module otsu_threshold_binarizer #(
  parameter int COUNT_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_level,
  output logic [7:0] out_mask,
  output logic       out_overflow
);

  otb_pkg::cmd_t    cmd;
  otb_pkg::status_t sts;

  otb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  otb_dp #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_level    (out_level),
    .out_mask     (out_mask),
    .out_overflow (out_overflow)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int COUNT_BITS = 20;
  localparam int QUIET_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic       op;
    logic [7:0] pixel;
    logic       last;
  } pixel_item_t;

  typedef struct {
    logic       kind;
    logic [7:0] level;
    logic [7:0] mask;
    logic       overflow;
  } binarize_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = 1'b0;
  logic [7:0] in_pixel = 8'd0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_level;
  logic [7:0] out_mask;
  logic       out_overflow;

  pixel_item_t      pending_pixels[$];
  binarize_result_t expected_results[$];
  int               total_items;
  int               sent_items = 0;
  int               fail_count = 0;
  int               quiet_cycles = 0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;

  logic [COUNT_BITS-1:0] gray_hist[256];
  logic [COUNT_BITS-1:0] frame_pixels;
  logic [7:0]            thresh_level;
  logic                  frame_dropped;

  otsu_threshold_binarizer #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_pixel(in_pixel), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_level(out_level),
    .out_mask(out_mask), .out_overflow(out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] otsu_pick();
    logic [255:0] total, sum_all, w_b, s_b, w_f, x, y, d, num, den;
    logic [255:0] best_num, best_den;
    logic [7:0]   pick;
    total = frame_pixels;
    sum_all = 0;
    w_b = 0;
    s_b = 0;
    best_num = 0;
    best_den = 1;
    pick = 8'd0;
    for (int i = 0; i < 256; i++) sum_all += i * gray_hist[i];
    for (int i = 0; i < 256; i++) begin
      w_b += gray_hist[i];
      s_b += i * gray_hist[i];
      w_f = total - w_b;
      if (w_b > 0 && w_f > 0) begin
        x = s_b * total;
        y = sum_all * w_b;
        d = (x >= y) ? x - y : y - x;
        num = d * d;
        den = w_b * w_f;
        if (num * best_den >= best_num * den) begin
          pick = i[7:0];
          best_num = num;
          best_den = den;
        end
      end
    end
    return pick;
  endfunction

  task automatic predict_pixel(input logic op, input logic [7:0] pixel, input logic last);
    binarize_result_t r;
    if (op == otb_pkg::OP_CLS) begin
      r.kind = otb_pkg::KIND_MASK;
      r.level = 8'd0;
      r.mask = (pixel <= thresh_level) ? otb_pkg::MASK_SET : 8'd0;
      r.overflow = 1'b0;
      expected_results.push_back(r);
    end else begin
      if (frame_pixels == {COUNT_BITS{1'b1}}) begin
        frame_dropped = 1'b1;
      end else begin
        gray_hist[pixel]++;
        frame_pixels++;
      end
      if (last) begin
        thresh_level = otsu_pick();
        r.kind = otb_pkg::KIND_THR;
        r.level = thresh_level;
        r.mask = 8'd0;
        r.overflow = frame_dropped;
        expected_results.push_back(r);
        foreach (gray_hist[i]) gray_hist[i] = '0;
        frame_pixels = '0;
        frame_dropped = 1'b0;
      end
    end
  endtask

  function automatic void add_item(logic op, logic [7:0] pixel, logic last);
    pixel_item_t it;
    it.op = op;
    it.pixel = pixel;
    it.last = last;
    pending_pixels.push_back(it);
  endfunction

  function automatic int phase_of();
    if (sent_items < total_items / 3) return 0;
    if (sent_items < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  // input side: prediction on transfer, then next item
  always @(posedge clk) begin
    pixel_item_t it;
    int idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pixel(in_op, in_pixel, in_last);
        sent_items++;
      end
      if (!in_valid || !in_stall) begin
        idle_pct = (phase_of() == 0) ? 37 : (phase_of() == 1) ? 73 : 0;
        if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          it = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_op <= it.op;
          in_pixel <= it.pixel;
          in_last <= it.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: checking, stalls, watchdog
  always @(posedge clk) begin
    binarize_result_t e;
    int stall_pct;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer kind=%0d", out_kind);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind expected %0d actual %0d", e.kind, out_kind);
            fail_count++;
          end
          if (out_level !== e.level) begin
            $error("level expected %0d actual %0d", e.level, out_level);
            fail_count++;
          end
          if (out_mask !== e.mask) begin
            $error("mask expected %0d actual %0d", e.mask, out_mask);
            fail_count++;
          end
          if (out_overflow !== e.overflow) begin
            $error("overflow expected %0d actual %0d", e.overflow, out_overflow);
            fail_count++;
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        if (!hold_done && sent_items >= 150) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        stall_pct = (phase_of() == 0) ? 73 : (phase_of() == 1) ? 37 : 0;
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
      end
    end
  end

  initial begin
    int flen, base, spread;
    foreach (gray_hist[i]) gray_hist[i] = '0;
    frame_pixels = '0;
    thresh_level = 8'd0;
    frame_dropped = 1'b0;

    // directed: reset threshold, single-valued frame, extremes, tie
    add_item(otb_pkg::OP_CLS, 8'd0, 1'b0);
    add_item(otb_pkg::OP_CLS, 8'd255, 1'b1);
    add_item(otb_pkg::OP_ACC, 8'd7, 1'b1);
    add_item(otb_pkg::OP_ACC, 8'd7, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'd7, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'd7, 1'b1);
    add_item(otb_pkg::OP_ACC, 8'd0, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'd255, 1'b1);
    add_item(otb_pkg::OP_CLS, 8'd255, 1'b0);
    add_item(otb_pkg::OP_CLS, 8'd0, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'd10, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'd20, 1'b1);
    add_item(otb_pkg::OP_CLS, 8'd19, 1'b0);
    add_item(otb_pkg::OP_CLS, 8'd20, 1'b1);
    add_item(otb_pkg::OP_ACC, 8'hAA, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'h55, 1'b0);
    add_item(otb_pkg::OP_ACC, 8'hAA, 1'b1);
    add_item(otb_pkg::OP_CLS, 8'h55, 1'b0);

    while (pending_pixels.size() < 540) begin
      flen = $urandom_range(1, 20);
      if ($urandom_range(0, 11) == 0) begin
        base = 0;
        spread = 255;
      end else begin
        spread = $urandom_range(0, 15);
        base = $urandom_range(0, 255 - spread);
      end
      for (int i = 0; i < flen; i++) begin
        if ($urandom_range(0, 99) < 30)
          add_item(otb_pkg::OP_CLS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_item(otb_pkg::OP_ACC, 8'(base + $urandom_range(0, spread)), i == flen - 1);
      end
    end
    total_items = pending_pixels.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_pixels.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/otb_pkg.sv
rtl/otb_ram.sv
rtl/otb_mul.sv
rtl/otb_ctrl.sv
rtl/otb_dp.sv
rtl/otsu_threshold_binarizer.sv
bench/testbench.sv
